>>> rtl/core/dsg_pkg.sv
// ----------------------------------------------------------------------------
// dsg_pkg
// Shared widths, command codes and the control bundles between the DSATUR
// controller and its datapath.
// ----------------------------------------------------------------------------
package dsg_pkg;

	localparam int CMD_W   = 2;
	localparam int VTX_W   = 6;
	localparam int COLOR_W = 6;
	localparam int COUNT_W = 7;

	localparam logic [CMD_W-1:0] CMD_ARC   = 2'd0;
	localparam logic [CMD_W-1:0] CMD_RUN   = 2'd1;
	localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

	localparam logic [COUNT_W-1:0] VCOUNT_RESET = 7'd64;

	typedef struct packed {
		logic accept_arc;
		logic clear;
		logic run_init;
		logic arc_rd;
		logic arc_wr;
		logic scan_step;
		logic pick_rd;
		logic search_load;
		logic search_step;
		logic commit;
		logic upd_step;
		logic round_inc;
		logic out_load;
	} dsg_cmd_t;

	typedef struct packed {
		logic sweep_done;
		logic search_done;
		logic last_round;
		logic out_last;
		logic out_free;
	} dsg_status_t;

endpackage

>>> rtl/core/dsg_if.sv
// ----------------------------------------------------------------------------
// dsg_if
// Valid/ready channels for the request words and the result words.
// ----------------------------------------------------------------------------
interface dsg_in_if import dsg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CMD_W-1:0]   cmd;
	logic [VTX_W-1:0]   from_vertex;
	logic [VTX_W-1:0]   to_vertex;

	modport source (output valid, output cmd, output from_vertex, output to_vertex,
		input ready);
	modport sink (input valid, input cmd, input from_vertex, input to_vertex,
		output ready);
endinterface

interface dsg_out_if import dsg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VTX_W-1:0]   vertex;
	logic [COLOR_W-1:0] color;
	logic               last;

	modport source (output valid, output vertex, output color, output last,
		input ready);
	modport sink (input valid, input vertex, input color, input last,
		output ready);
endinterface

>>> rtl/core/dsatur_graph_coloring.sv
// ----------------------------------------------------------------------------
// dsatur_graph_coloring
// DSATUR greedy graph coloring engine with a loadable adjacency matrix.
// ----------------------------------------------------------------------------
//  Channel   Dir  Word contents                     Accepted when
//  request   in   cmd, from_vertex, to_vertex       valid && ready
//  result    out  vertex, color, last               valid && ready
//  cfg       in   cfg_wr_data (vertex total)        cfg_wr_en
//
//  An arc word goes through a read and a write state. A run word with n
//  vertices takes n rounds, each two sweeps over the vertex RAMs plus a
//  first-fit color search, then a read and a show state per result word.
//  Results are shown from an output register; the last one may wait there
//  while new request words are taken. Reset leaves an empty graph with the
//  vertex total at 64; a stalled non-last result holds the block in readout.
// ----------------------------------------------------------------------------
module dsatur_graph_coloring import dsg_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data,
	dsg_in_if.sink             request,
	dsg_out_if.source          result
);

	dsg_cmd_t    cmd;
	dsg_status_t status;

	dsg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (request.valid),
		.in_cmd   (request.cmd),
		.in_ready (request.ready),
		.status   (status),
		.cmd      (cmd)
	);

	dsg_datapath #(.MAX_VERTICES(MAX_VERTICES)) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.from_vertex (request.from_vertex),
		.to_vertex   (request.to_vertex),
		.cmd         (cmd),
		.status      (status),
		.out_ready   (result.ready),
		.out_valid   (result.valid),
		.out_vertex  (result.vertex),
		.out_color   (result.color),
		.out_last    (result.last)
	);

endmodule

>>> rtl/core/dsg_ram.sv
// ----------------------------------------------------------------------------
// dsg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module dsg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

>>> rtl/core/dsg_ctrl.sv
// ----------------------------------------------------------------------------
// dsg_ctrl
// Controller state machine: sequences arc loading, the DSATUR rounds and the
// result readout.
// ----------------------------------------------------------------------------
module dsg_ctrl import dsg_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic [CMD_W-1:0] in_cmd,
	output logic             in_ready,
	input  dsg_status_t      status,
	output dsg_cmd_t         cmd
);

	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_ARC_RD   = 4'd1;
	localparam logic [3:0] S_ARC_WR   = 4'd2;
	localparam logic [3:0] S_SCAN     = 4'd3;
	localparam logic [3:0] S_PICK     = 4'd4;
	localparam logic [3:0] S_SLOAD    = 4'd5;
	localparam logic [3:0] S_SEARCH   = 4'd6;
	localparam logic [3:0] S_UPDATE   = 4'd7;
	localparam logic [3:0] S_OUT_RD   = 4'd8;
	localparam logic [3:0] S_OUT_SHOW = 4'd9;

	logic [3:0] state_q;
	logic [3:0] state_d;
	logic       in_fire;

	assign in_ready = (state_q == S_IDLE);
	assign in_fire  = in_valid && in_ready;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_fire) begin
					case (in_cmd)
						CMD_ARC: begin
							cmd.accept_arc = 1'b1;
							state_d        = S_ARC_RD;
						end
						CMD_RUN: begin
							cmd.run_init = 1'b1;
							state_d      = S_SCAN;
						end
						CMD_CLEAR: begin
							cmd.clear = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			S_ARC_RD: begin
				cmd.arc_rd = 1'b1;
				state_d    = S_ARC_WR;
			end
			S_ARC_WR: begin
				cmd.arc_wr = 1'b1;
				state_d    = S_IDLE;
			end
			S_SCAN: begin
				cmd.scan_step = 1'b1;
				if (status.sweep_done) begin
					state_d = S_PICK;
				end
			end
			S_PICK: begin
				cmd.pick_rd = 1'b1;
				state_d     = S_SLOAD;
			end
			S_SLOAD: begin
				cmd.search_load = 1'b1;
				state_d         = S_SEARCH;
			end
			S_SEARCH: begin
				if (status.search_done) begin
					cmd.commit = 1'b1;
					state_d    = S_UPDATE;
				end else begin
					cmd.search_step = 1'b1;
				end
			end
			S_UPDATE: begin
				cmd.upd_step = 1'b1;
				if (status.sweep_done) begin
					cmd.round_inc = 1'b1;
					state_d       = status.last_round ? S_OUT_RD : S_SCAN;
				end
			end
			S_OUT_RD: begin
				if (status.out_free) begin
					state_d = S_OUT_SHOW;
				end
			end
			S_OUT_SHOW: begin
				cmd.out_load = 1'b1;
				state_d      = status.out_last ? S_IDLE : S_OUT_RD;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/dsg_datapath.sv
// ----------------------------------------------------------------------------
// dsg_datapath
// Graph storage, saturation bookkeeping, the candidate sweep, the first-fit
// color search and the result register.
// ----------------------------------------------------------------------------
module dsg_datapath import dsg_pkg::*; #(
	parameter int MAX_VERTICES = 64
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_wr_en,
	input  logic [COUNT_W-1:0] cfg_wr_data,
	input  logic [VTX_W-1:0]   from_vertex,
	input  logic [VTX_W-1:0]   to_vertex,
	input  dsg_cmd_t           cmd,
	output dsg_status_t        status,
	input  logic               out_ready,
	output logic               out_valid,
	output logic [VTX_W-1:0]   out_vertex,
	output logic [COLOR_W-1:0] out_color,
	output logic               out_last
);

	localparam int IW = $clog2(MAX_VERTICES);
	localparam int CW = $clog2(MAX_VERTICES + 1);
	localparam logic [MAX_VERTICES-1:0] BIT0 = {{(MAX_VERTICES-1){1'b0}}, 1'b1};

	logic [COUNT_W-1:0]      vcount_q;
	logic [CW-1:0]           n_eff;
	logic [IW-1:0]           n_last;
	logic [MAX_VERTICES-1:0] in_play;

	logic [IW-1:0]           from_q;
	logic [IW-1:0]           to_q;
	logic                    arc_ok_q;
	logic [MAX_VERTICES-1:0] adj_valid_q;
	logic [MAX_VERTICES-1:0] nc_valid_q;
	logic [MAX_VERTICES-1:0] colored_q;
	logic [CW-1:0]           u_q;
	logic [IW-1:0]           u_idx;
	logic                    sw_valid_s1;
	logic [IW-1:0]           sw_u_s1;
	logic                    found_q;
	logic [IW-1:0]           best_q;
	logic [COUNT_W-1:0]      best_sat_q;
	logic [COUNT_W-1:0]      best_deg_q;
	logic [MAX_VERTICES-1:0] word_q;
	logic [MAX_VERTICES-1:0] target_q;
	logic [IW-1:0]           c_q;
	logic [IW-1:0]           round_q;
	logic [IW-1:0]           v_q;
	logic                    out_valid_q;
	logic [VTX_W-1:0]        out_vertex_q;
	logic [COLOR_W-1:0]      out_color_q;
	logic                    out_last_q;

	logic [MAX_VERTICES-1:0] adj_rdata;
	logic [COUNT_W-1:0]      deg_rdata;
	logic [MAX_VERTICES-1:0] nc_rdata;
	logic [COUNT_W-1:0]      sat_rdata;
	logic [COLOR_W-1:0]      vcol_rdata;

	logic [MAX_VERTICES-1:0] adj_row;
	logic                    arc_new;
	logic [COUNT_W-1:0]      deg_old;
	logic                    sweep_issue;
	logic [COUNT_W-1:0]      sw_sat;
	logic [COUNT_W-1:0]      sw_deg;
	logic                    sw_take;
	logic                    upd_wr;
	logic [MAX_VERTICES-1:0] upd_old;

	always_comb begin
		if (vcount_q == '0) begin
			n_eff = CW'(1);
		end else if (vcount_q > COUNT_W'(MAX_VERTICES)) begin
			n_eff = CW'(MAX_VERTICES);
		end else begin
			n_eff = vcount_q[CW-1:0];
		end
	end

	assign n_last = IW'(n_eff - CW'(1));

	for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_play
		assign in_play[i] = (CW'(i) < n_eff);
	end

	assign u_idx       = u_q[IW-1:0];
	assign sweep_issue = (cmd.scan_step || cmd.upd_step) && (u_q < n_eff);

	assign adj_row = adj_valid_q[from_q] ? adj_rdata : '0;
	assign deg_old = adj_valid_q[from_q] ? deg_rdata : '0;
	assign arc_new = arc_ok_q && !adj_row[to_q];

	assign sw_sat  = nc_valid_q[sw_u_s1] ? sat_rdata : '0;
	assign sw_deg  = adj_valid_q[sw_u_s1] ? deg_rdata : '0;
	assign sw_take = cmd.scan_step && sw_valid_s1 && !colored_q[sw_u_s1] &&
		(!found_q || (sw_sat > best_sat_q) ||
		((sw_sat == best_sat_q) && (sw_deg > best_deg_q)));

	assign upd_wr  = cmd.upd_step && sw_valid_s1;
	assign upd_old = nc_valid_q[sw_u_s1] ? nc_rdata : '0;

	dsg_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj_ram (
		.clk   (clk),
		.we    (cmd.arc_wr && arc_new),
		.waddr (from_q),
		.wdata (adj_row | (BIT0 << to_q)),
		.raddr (cmd.arc_rd ? from_q : best_q),
		.rdata (adj_rdata)
	);

	dsg_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_VERTICES)) u_deg_ram (
		.clk   (clk),
		.we    (cmd.arc_wr && arc_new),
		.waddr (from_q),
		.wdata (deg_old + COUNT_W'(1)),
		.raddr (cmd.arc_rd ? from_q : u_idx),
		.rdata (deg_rdata)
	);

	dsg_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_nc_ram (
		.clk   (clk),
		.we    (upd_wr),
		.waddr (sw_u_s1),
		.wdata (upd_old | (BIT0 << c_q)),
		.raddr (cmd.pick_rd ? best_q : u_idx),
		.rdata (nc_rdata)
	);

	dsg_ram #(.WIDTH(COUNT_W), .DEPTH(MAX_VERTICES)) u_sat_ram (
		.clk   (clk),
		.we    (upd_wr),
		.waddr (sw_u_s1),
		.wdata (sw_sat + (upd_old[c_q] ? COUNT_W'(0) : COUNT_W'(1))),
		.raddr (u_idx),
		.rdata (sat_rdata)
	);

	dsg_ram #(.WIDTH(COLOR_W), .DEPTH(MAX_VERTICES)) u_vcol_ram (
		.clk   (clk),
		.we    (cmd.commit),
		.waddr (best_q),
		.wdata (COLOR_W'(c_q)),
		.raddr (v_q),
		.rdata (vcol_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcount_q    <= VCOUNT_RESET;
			adj_valid_q <= '0;
			nc_valid_q  <= '0;
			colored_q   <= '0;
			u_q         <= '0;
			sw_valid_s1 <= 1'b0;
			found_q     <= 1'b0;
			c_q         <= '0;
			round_q     <= '0;
			v_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				vcount_q <= cfg_wr_data;
			end

			if (cmd.clear) begin
				adj_valid_q <= '0;
			end else if (cmd.arc_wr && arc_new) begin
				adj_valid_q[from_q] <= 1'b1;
			end

			if (cmd.clear || cmd.run_init) begin
				nc_valid_q <= '0;
			end else if (upd_wr) begin
				nc_valid_q[sw_u_s1] <= 1'b1;
			end

			if (cmd.clear || cmd.run_init) begin
				colored_q <= '0;
			end else if (cmd.commit) begin
				colored_q[best_q] <= 1'b1;
			end

			if (cmd.run_init || cmd.round_inc || cmd.commit) begin
				u_q <= '0;
			end else if (sweep_issue) begin
				u_q <= u_q + CW'(1);
			end

			sw_valid_s1 <= sweep_issue && (cmd.scan_step || target_q[u_idx]);

			if (cmd.run_init || cmd.round_inc) begin
				found_q <= 1'b0;
			end else if (sw_take) begin
				found_q <= 1'b1;
			end

			if (cmd.search_load) begin
				c_q <= '0;
			end else if (cmd.search_step) begin
				c_q <= c_q + IW'(1);
			end

			if (cmd.run_init) begin
				round_q <= '0;
			end else if (cmd.round_inc) begin
				round_q <= round_q + IW'(1);
			end

			if (cmd.run_init) begin
				v_q <= '0;
			end else if (cmd.out_load) begin
				v_q <= v_q + IW'(1);
			end

			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept_arc) begin
			from_q   <= from_vertex[IW-1:0];
			to_q     <= to_vertex[IW-1:0];
			arc_ok_q <= (COUNT_W'(from_vertex) < COUNT_W'(n_eff)) &&
				(COUNT_W'(to_vertex) < COUNT_W'(n_eff));
		end
		sw_u_s1 <= u_idx;
		if (sw_take) begin
			best_q     <= sw_u_s1;
			best_sat_q <= sw_sat;
			best_deg_q <= sw_deg;
		end
		if (cmd.search_load) begin
			word_q   <= nc_valid_q[best_q] ? nc_rdata : '0;
			target_q <= (adj_valid_q[best_q] ? adj_rdata : '0) & in_play &
				~colored_q & ~(BIT0 << best_q);
		end
		if (cmd.out_load) begin
			out_vertex_q <= VTX_W'(v_q);
			out_color_q  <= vcol_rdata;
			out_last_q   <= (v_q == n_last);
		end
	end

	assign status.sweep_done  = (u_q == n_eff) && !sw_valid_s1;
	assign status.search_done = !((c_q < IW'(MAX_VERTICES - 1)) && word_q[c_q]);
	assign status.last_round  = (round_q == n_last);
	assign status.out_last    = (v_q == n_last);
	assign status.out_free    = !out_valid_q || out_ready;

	assign out_valid  = out_valid_q;
	assign out_vertex = out_vertex_q;
	assign out_color  = out_color_q;
	assign out_last   = out_last_q;

endmodule

>>> rtl/core/dsg_checker.sv
// ----------------------------------------------------------------------------
// dsg_checker
// Port-level assertions for the DSATUR coloring engine, bound to the top.
// ----------------------------------------------------------------------------
module dsg_checker import dsg_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               req_valid,
	input logic               req_ready,
	input logic [CMD_W-1:0]   req_cmd,
	input logic               res_valid,
	input logic               res_ready,
	input logic [VTX_W-1:0]   res_vertex,
	input logic [COLOR_W-1:0] res_color,
	input logic               res_last
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_vertex) &&
		$stable(res_color) && $stable(res_last))
		else $error("result word changed while stalled");

	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_cmd == CMD_ARC || req_cmd == CMD_RUN)
		|=> !req_ready)
		else $error("request taken while an arc or run is in progress");

	a_readout_busy: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_last |-> !req_ready)
		else $error("request ready in the middle of a readout");

	a_result_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_ready && !res_last |=> !res_valid)
		else $error("next result word shown without a RAM read cycle");

endmodule

bind dsatur_graph_coloring dsg_checker u_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (request.valid),
	.req_ready  (request.ready),
	.req_cmd    (request.cmd),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_vertex (result.vertex),
	.res_color  (result.color),
	.res_last   (result.last)
);
